// ===== rtl/core/jpdr_pkg.sv =====
// Shared types and constants for the joystick pose dead-reckoning block.
// Holds the input and output word layouts, controller states and datapath command codes.
// No dependencies.
`default_nettype none

package jpdr_pkg;

  localparam int unsigned STAGE_IDX_W = 5;

  localparam logic        CMD_EVENT       = 1'b0;
  localparam logic        CMD_TICK        = 1'b1;
  localparam logic [6:0]  EVT_KIND_AXIS   = 7'h02;
  localparam logic [7:0]  AXIS_FORWARD    = 8'd1;
  localparam logic [7:0]  AXIS_TURN       = 8'd2;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [27:0] TURN_SCALE      = 28'sd85445659;

  localparam logic [31:0] ATAN_Q32 [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0
  };

  typedef struct packed {
    logic               cmd;
    logic [7:0]         event_kind;
    logic [7:0]         axis_number;
    logic signed [15:0] axis_value;
    logic [20:0]        elapsed;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [15:0] linear_rate;
    logic signed [15:0] turn_rate;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT,
    ST_MVC,
    ST_MVS,
    ST_MXS,
    ST_MYS,
    ST_MWS,
    ST_MWK,
    ST_FIN
  } jpdr_state_e;

  typedef enum logic [2:0] {
    MUL_VC,
    MUL_VS,
    MUL_XS,
    MUL_YS,
    MUL_WS,
    MUL_WK
  } mul_op_e;

  typedef struct packed {
    logic                   evt_load;
    logic                   tick_load;
    logic                   rot_step;
    logic [STAGE_IDX_W-1:0] stage;
    logic                   mul_en;
    mul_op_e                mul_op;
    logic                   cap_rx;
    logic                   cap_ry;
    logic                   cap_dx;
    logic                   cap_dy;
    logic                   commit;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/jpdr_ctrl.sv =====
// Controller for the pose integrator: handshakes, CORDIC iteration count, multiply sequence.
// Depends on jpdr_pkg; drives the datapath through a dp_cmd_t command word.
`default_nettype none

module jpdr_ctrl
  import jpdr_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 20
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_cmd_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output dp_cmd_t      cmd_o
);

  localparam int unsigned CNT_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STAGES - 1);

  jpdr_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              in_fire;
  logic              slot_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = '0;
    out_valid_d = out_valid_q && out_stall_i;

    cmd_o           = '0;
    cmd_o.mul_op    = MUL_VC;
    cmd_o.stage     = STAGE_IDX_W'(cnt_q);

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd_i == CMD_TICK) begin
            cmd_o.tick_load = 1'b1;
            state_d         = ST_ROT;
          end else begin
            cmd_o.evt_load = 1'b1;
          end
        end
      end
      ST_ROT: begin
        cmd_o.rot_step = 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_MVC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MVC: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_VC;
        state_d      = ST_MVS;
      end
      ST_MVS: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_VS;
        cmd_o.cap_rx = 1'b1;
        state_d      = ST_MXS;
      end
      ST_MXS: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_XS;
        cmd_o.cap_ry = 1'b1;
        state_d      = ST_MYS;
      end
      ST_MYS: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_YS;
        cmd_o.cap_dx = 1'b1;
        state_d      = ST_MWS;
      end
      ST_MWS: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_WS;
        cmd_o.cap_dy = 1'b1;
        state_d      = ST_MWK;
      end
      ST_MWK: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_WK;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/jpdr_dp.sv =====
// Datapath for the pose integrator: axis latches, CORDIC rotator, shared multiplier,
// pose accumulators and output word register. Depends on jpdr_pkg; driven by jpdr_ctrl.
`default_nettype none

module jpdr_dp
  import jpdr_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_word_t in_word_i,
  input  wire dp_cmd_t  cmd_i,
  output out_word_t     out_word_o
);

  localparam int unsigned ZW         = ANGLE_BITS + 1;
  localparam int unsigned CW         = 34;
  localparam int unsigned MAW        = 40;
  localparam int unsigned MBW        = 28;
  localparam int unsigned PW         = MAW + MBW;
  localparam int unsigned UP_SHIFT   = (ANGLE_BITS >= 32) ? ANGLE_BITS - 32 : 0;
  localparam int unsigned DOWN_SHIFT = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;
  localparam logic [63:0] HALF_LSB   = (64'd1 << DOWN_SHIFT) >> 1;
  localparam logic signed [PW-1:0] RND15 = PW'(1) << 14;
  localparam logic signed [PW-1:0] RND31 = PW'(1) << 31;
  localparam logic signed [PW-1:0] RND33 = PW'(1) << 33;

  // pose state
  logic [31:0]        x_q, y_q, yaw_q;
  logic signed [15:0] fwd_q, turn_q;

  // tick working registers
  logic [20:0]             span_q;
  logic                    flip_q;
  logic signed [ZW-1:0]    z_q, z_d;
  logic signed [CW-1:0]    px_q, px_d, py_q, py_d;
  logic signed [PW-1:0]    p_q, prod;
  logic signed [MAW-1:0]   rx_q, ry_q;
  logic [31:0]             dx_q, dy_q;
  out_word_t               out_q;

  logic signed [15:0]      lin_rate, ang_rate;
  logic [63:0]             yaw_ext, a_full, atan_ext, ang_full;
  logic [ANGLE_BITS-1:0]   a_ang, a_fold;
  logic                    a_flip;
  logic signed [ZW-1:0]    stage_ang;
  logic signed [CW-1:0]    sx, sy, cos_v, sin_v;
  logic signed [MAW-1:0]   mul_a;
  logic signed [MBW-1:0]   mul_b;
  logic signed [PW-1:0]    rnd15_sum, rnd31_sum, rnd33_sum;
  logic [31:0]             dyaw;

  assign lin_rate = (fwd_q == 16'sh8000) ? 16'sd32767 : -fwd_q;
  assign ang_rate = (turn_q == 16'sh8000) ? 16'sd32767 : -turn_q;

  // heading to CORDIC angle, folded into [-1/4, 1/4) turn
  assign yaw_ext = {32'd0, yaw_q};
  assign a_full  = (yaw_ext << UP_SHIFT) >> DOWN_SHIFT;
  assign a_ang   = a_full[ANGLE_BITS-1:0];
  assign a_flip  = a_ang[ANGLE_BITS-1] ^ a_ang[ANGLE_BITS-2];
  assign a_fold  = a_flip ? {~a_ang[ANGLE_BITS-1], a_ang[ANGLE_BITS-2:0]} : a_ang;

  assign atan_ext  = {32'd0, ATAN_Q32[cmd_i.stage]};
  assign ang_full  = (ANGLE_BITS >= 32) ? (atan_ext << UP_SHIFT)
                                        : ((atan_ext + HALF_LSB) >> DOWN_SHIFT);
  assign stage_ang = ZW'(ang_full);

  assign sx = px_q >>> cmd_i.stage;
  assign sy = py_q >>> cmd_i.stage;

  always_comb begin
    if (!z_q[ZW-1]) begin
      px_d = px_q - sy;
      py_d = py_q + sx;
      z_d  = z_q - stage_ang;
    end else begin
      px_d = px_q + sy;
      py_d = py_q - sx;
      z_d  = z_q + stage_ang;
    end
  end

  assign cos_v = flip_q ? -px_q : px_q;
  assign sin_v = flip_q ? -py_q : py_q;

  always_comb begin
    case (cmd_i.mul_op)
      MUL_VC: begin
        mul_a = {{(MAW-CW){cos_v[CW-1]}}, cos_v};
        mul_b = {{(MBW-16){lin_rate[15]}}, lin_rate};
      end
      MUL_VS: begin
        mul_a = {{(MAW-CW){sin_v[CW-1]}}, sin_v};
        mul_b = {{(MBW-16){lin_rate[15]}}, lin_rate};
      end
      MUL_XS: begin
        mul_a = rx_q;
        mul_b = {{(MBW-21){1'b0}}, span_q};
      end
      MUL_YS: begin
        mul_a = ry_q;
        mul_b = {{(MBW-21){1'b0}}, span_q};
      end
      MUL_WS: begin
        mul_a = {{(MAW-16){ang_rate[15]}}, ang_rate};
        mul_b = {{(MBW-21){1'b0}}, span_q};
      end
      MUL_WK: begin
        mul_a = p_q[MAW-1:0];
        mul_b = TURN_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod      = mul_a * mul_b;
  assign rnd15_sum = p_q + RND15;
  assign rnd31_sum = p_q + RND31;
  assign rnd33_sum = p_q + RND33;
  assign dyaw      = rnd31_sum[63:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      yaw_q  <= '0;
      fwd_q  <= '0;
      turn_q <= '0;
    end else begin
      if (cmd_i.evt_load && (in_word_i.event_kind[6:0] == EVT_KIND_AXIS)) begin
        if (in_word_i.axis_number == AXIS_FORWARD) begin
          fwd_q <= in_word_i.axis_value;
        end else if (in_word_i.axis_number == AXIS_TURN) begin
          turn_q <= in_word_i.axis_value;
        end
      end
      if (cmd_i.commit) begin
        x_q   <= x_q + dx_q;
        y_q   <= y_q + dy_q;
        yaw_q <= yaw_q + dyaw;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_load) begin
      span_q <= in_word_i.elapsed;
      flip_q <= a_flip;
      z_q    <= {a_fold[ANGLE_BITS-1], a_fold};
      px_q   <= CORDIC_GAIN_Q30;
      py_q   <= '0;
    end else if (cmd_i.rot_step) begin
      z_q  <= z_d;
      px_q <= px_d;
      py_q <= py_d;
    end
    if (cmd_i.mul_en) begin
      p_q <= prod;
    end
    if (cmd_i.cap_rx) begin
      rx_q <= rnd15_sum[MAW+14:15];
    end
    if (cmd_i.cap_ry) begin
      ry_q <= rnd15_sum[MAW+14:15];
    end
    if (cmd_i.cap_dx) begin
      dx_q <= rnd33_sum[65:34];
    end
    if (cmd_i.cap_dy) begin
      dy_q <= rnd33_sum[65:34];
    end
    if (cmd_i.commit) begin
      out_q.pos_x       <= x_q + dx_q;
      out_q.pos_y       <= y_q + dy_q;
      out_q.heading     <= yaw_q + dyaw;
      out_q.linear_rate <= lin_rate;
      out_q.turn_rate   <= ang_rate;
    end
  end

  assign out_word_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/joystick_pose_dead_reckoning_top.sv =====
// Joystick-driven unicycle dead-reckoning block: top level.
// Depends on jpdr_pkg, jpdr_ctrl and jpdr_dp.
//
// Words with cmd clear are joystick events: an axis event (init flag ignored) on axis 1
// or 2 latches the forward or turn deflection and produces no output; the input is not
// stalled by it. Words with cmd set are ticks: rates are the negated, saturated
// deflections, the heading's cosine and sine come from a CORDIC that runs one stage per
// cycle, and one shared multiplier then runs six products in sequence before the pose
// is updated and one output word is registered. A tick stalls the input while the
// CORDIC iterations and the multiplier sequence run and until the word is committed, so
// a new tick is not taken before the last one is through; the commit waits while a
// previous output word is still held.
// Position is Q16.16 and wraps; heading is a binary angle where 2^32 is one turn.
`default_nettype none

module joystick_pose_dead_reckoning_top
  import jpdr_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 20,
  parameter int unsigned ANGLE_BITS    = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_word_t in_word_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_word_t     out_word_o
);

  dp_cmd_t dp_cmd;

  jpdr_ctrl #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_word_i.cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd)
  );

  jpdr_dp #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (dp_cmd),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

// ===== bench/joystick_pose_dead_reckoning_top_test.sv =====
// Testbench for joystick_pose_dead_reckoning_top: directed and random joystick and tick words.
// A scoreboard class predicts pose, heading and rates for each tick and checks every output word.
// Depends on jpdr_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module joystick_pose_dead_reckoning_top_test;
  import jpdr_pkg::*;

  localparam int unsigned CORDIC_N      = 20;
  localparam int unsigned RANDOM_ITEMS  = 1550;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam logic [7:0]  INIT_FLAG     = 8'h80;
  localparam logic [6:0]  EVT_KIND_BTN  = 7'h01;
  localparam logic [20:0] ONE_SECOND    = 21'd1048576;
  localparam logic [20:0] SPAN_MAX      = 21'h1FFFFF;

  localparam longint ARC_STEP [0:19] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304
  };

  class pose_scoreboard;
    localparam longint GAIN_Q30   = 652032874;
    localparam longint RAD_TO_BAM = 85445659;
    localparam longint QUARTER    = 64'h4000_0000;
    localparam longint HALF       = 64'h8000_0000;
    localparam longint FULL_TURN  = 64'h1_0000_0000;

    bit [31:0]          x_acc, y_acc, yaw_acc;
    logic signed [15:0] fwd_axis, turn_axis;
    out_word_t          pose_q[$];
    int unsigned        fail_count, ticks_seen, axis_latched, words_dropped;

    function new();
      x_acc = '0;
      y_acc = '0;
      yaw_acc = '0;
      fwd_axis = '0;
      turn_axis = '0;
      fail_count = 0;
      ticks_seen = 0;
      axis_latched = 0;
      words_dropped = 0;
    endfunction

    function int unsigned pending();
      return pose_q.size();
    endfunction

    function longint round_down_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint neg_rate(logic signed [15:0] a);
      longint n;
      n = -longint'(a);
      return (n > 32767) ? 32767 : n;
    endfunction

    function void heading_sin_cos(bit [31:0] ang, output longint c, output longint s);
      longint z, px, py, sx, sy;
      bit     flip;
      int     i;
      z = {32'b0, ang};
      flip = 1'b0;
      if (z >= QUARTER && z < 3 * QUARTER) begin
        z -= HALF;
        flip = 1'b1;
      end else if (z >= 3 * QUARTER) begin
        z -= FULL_TURN;
      end
      px = GAIN_Q30;
      py = 0;
      for (i = 0; i < CORDIC_N; i++) begin
        sx = px >>> i;
        sy = py >>> i;
        if (z >= 0) begin
          px -= sy;
          py += sx;
          z -= ARC_STEP[i];
        end else begin
          px += sy;
          py -= sx;
          z += ARC_STEP[i];
        end
      end
      c = flip ? -px : px;
      s = flip ? -py : py;
    endfunction

    function void integrate_tick(logic [20:0] elapsed);
      longint    v, r, c, s, span, dx, dy, dyaw;
      out_word_t e;
      span = {43'b0, elapsed};
      v = neg_rate(fwd_axis);
      r = neg_rate(turn_axis);
      heading_sin_cos(yaw_acc, c, s);
      dx = round_down_shift(round_down_shift(v * c, 15) * span, 34);
      dy = round_down_shift(round_down_shift(v * s, 15) * span, 34);
      dyaw = round_down_shift(r * span * RAD_TO_BAM, 32);
      x_acc += dx[31:0];
      y_acc += dy[31:0];
      yaw_acc += dyaw[31:0];
      e.pos_x = x_acc;
      e.pos_y = y_acc;
      e.heading = yaw_acc;
      e.linear_rate = v[15:0];
      e.turn_rate = r[15:0];
      pose_q.push_back(e);
      ticks_seen++;
    endfunction

    function void note_word(in_word_t w);
      if (w.cmd == CMD_TICK) begin
        integrate_tick(w.elapsed);
      end else if (w.event_kind[6:0] == EVT_KIND_AXIS && w.axis_number == AXIS_FORWARD) begin
        fwd_axis = w.axis_value;
        axis_latched++;
      end else if (w.event_kind[6:0] == EVT_KIND_AXIS && w.axis_number == AXIS_TURN) begin
        turn_axis = w.axis_value;
        axis_latched++;
      end else begin
        words_dropped++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      if (pose_q.size() == 0) begin
        $error("unexpected output word %h", got);
        fail_count++;
        return;
      end
      e = pose_q.pop_front();
      if (got.pos_x !== e.pos_x) begin
        $error("pos_x expected %0d got %0d", e.pos_x, got.pos_x);
        fail_count++;
      end
      if (got.pos_y !== e.pos_y) begin
        $error("pos_y expected %0d got %0d", e.pos_y, got.pos_y);
        fail_count++;
      end
      if (got.heading !== e.heading) begin
        $error("heading expected %0d got %0d", e.heading, got.heading);
        fail_count++;
      end
      if (got.linear_rate !== e.linear_rate) begin
        $error("linear_rate expected %0d got %0d", e.linear_rate, got.linear_rate);
        fail_count++;
      end
      if (got.turn_rate !== e.turn_rate) begin
        $error("turn_rate expected %0d got %0d", e.turn_rate, got.turn_rate);
        fail_count++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  pose_scoreboard sb = new();

  bit          calm_phase = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned gap_pct = 10;
  int unsigned stall_pct = 10;
  int unsigned stall_left = 0;
  int unsigned stall_window = 0;

  joystick_pose_dead_reckoning_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      sb.check_word(out_word_o);
    end
  end

  // receiver stalls in bursts; rate re-picked per window, zero gives clean stretches
  always @(negedge clk_i) begin
    if (calm_phase) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_stall_i <= 1'b0;
    end
    stall_window++;
    if (stall_window == 200) begin
      stall_window = 0;
      stall_pct = $urandom_range(0, 3) * 10;
    end
  end

  function automatic in_word_t make_word(logic cmd, logic [7:0] kind, logic [7:0] num,
                                         logic signed [15:0] val, logic [20:0] elapsed);
    in_word_t w;
    w.cmd = cmd;
    w.event_kind = kind;
    w.axis_number = num;
    w.axis_value = val;
    w.elapsed = elapsed;
    return w;
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(in_word_t w);
    if (words_sent % 100 == 0) gap_pct = $urandom_range(0, 3) * 10;
    words_sent++;
    if (!calm_phase && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_word(w);
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    if (sb.pending() != 0) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while (sb.pending() != 0);
    end
  endtask

  function automatic logic [20:0] pick_span();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 21'($urandom_range(0, ONE_SECOND));
      5, 6, 7:       return 21'($urandom_range(0, 4095));
      default:       return 21'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_axis_value();
    case ($urandom_range(0, 19))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    in_word_t    w;
    int unsigned live_items;
    int unsigned pick;
    bit          drained_mid;
    live_items = 0;
    drained_mid = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero rates, saturation, init flag, ignored words, long spans
    send_word(make_word(CMD_TICK, 8'h00, 8'h00, 16'sh0000, 21'd0));
    send_word(make_word(CMD_TICK, 8'h00, 8'h00, 16'sh0000, ONE_SECOND));
    send_word(make_word(CMD_EVENT, {1'b0, EVT_KIND_AXIS}, AXIS_FORWARD, 16'sh8000, 21'd0));
    send_word(make_word(CMD_EVENT, INIT_FLAG | {1'b0, EVT_KIND_AXIS}, AXIS_TURN, 16'sh7FFF,
                        21'd0));
    send_word(make_word(CMD_TICK, 8'h00, 8'h00, 16'sh0000, ONE_SECOND));
    send_word(make_word(CMD_TICK, 8'hFF, 8'hFF, 16'shFFFF, SPAN_MAX));
    send_word(make_word(CMD_EVENT, {1'b0, EVT_KIND_AXIS}, 8'd0, 16'sd12345, 21'd0));
    send_word(make_word(CMD_EVENT, {1'b0, EVT_KIND_AXIS}, 8'd3, 16'sh8000, 21'd0));
    send_word(make_word(CMD_EVENT, {1'b0, EVT_KIND_BTN}, AXIS_FORWARD, 16'sd1000, 21'd0));
    send_word(make_word(CMD_EVENT, 8'hFF, 8'hFF, 16'shFFFF, SPAN_MAX));
    send_word(make_word(CMD_EVENT, INIT_FLAG | {1'b0, EVT_KIND_BTN}, AXIS_TURN, 16'sd77,
                        21'd0));
    send_word(make_word(CMD_TICK, {1'b0, EVT_KIND_AXIS}, AXIS_FORWARD, 16'sd5, 21'd777));
    send_word(make_word(CMD_EVENT, {1'b0, EVT_KIND_AXIS}, AXIS_FORWARD, 16'sh7FFF, SPAN_MAX));
    send_word(make_word(CMD_EVENT, INIT_FLAG | {1'b0, EVT_KIND_AXIS}, AXIS_TURN, 16'sh8000,
                        21'd0));
    send_word(make_word(CMD_TICK, 8'h00, 8'h00, 16'sh0000, SPAN_MAX));
    send_word(make_word(CMD_TICK, 8'h00, 8'h00, 16'sh0000, 21'd1));
    send_word(make_word(CMD_EVENT, {1'b0, EVT_KIND_AXIS}, AXIS_FORWARD, 16'sh0000, 21'd0));
    send_word(make_word(CMD_EVENT, {1'b0, EVT_KIND_AXIS}, AXIS_TURN, -16'sd1, 21'd0));
    send_word(make_word(CMD_TICK, 8'h00, 8'h00, 16'sh0000, 21'd1048575));
    send_word(make_word(CMD_EVENT, {1'b0, EVT_KIND_AXIS}, AXIS_FORWARD, -16'sd20000, 21'd0));
    send_word(make_word(CMD_EVENT, {1'b0, EVT_KIND_AXIS}, AXIS_TURN, -16'sd32768, 21'd0));
    repeat (4) send_word(make_word(CMD_TICK, 8'h00, 8'h00, 16'sh0000, SPAN_MAX));
    wait_for_results();

    // random: mostly ticks and axis words, some noise
    while (live_items < RANDOM_ITEMS) begin
      w.cmd = CMD_EVENT;
      w.event_kind = 8'($urandom);
      w.axis_number = 8'($urandom);
      w.axis_value = pick_axis_value();
      w.elapsed = 21'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        w.cmd = CMD_TICK;
        w.elapsed = pick_span();
      end else if (pick < 85) begin
        w.event_kind = {w.event_kind[7], EVT_KIND_AXIS};
        w.axis_number = $urandom_range(0, 1) ? AXIS_FORWARD : AXIS_TURN;
      end else if (pick < 92) begin
        w.event_kind = {w.event_kind[7], EVT_KIND_AXIS};
      end
      live_items++;
      send_word(w);
      if (!drained_mid && live_items >= RANDOM_ITEMS / 2) begin
        drained_mid = 1'b1;
        wait_for_results();
      end
      if (live_items >= RANDOM_ITEMS * 85 / 100) calm_phase = 1'b1;
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("tb: %0d ticks checked, %0d axis words latched, %0d words ignored",
             sb.ticks_seen, sb.axis_latched, sb.words_dropped);
    $display("tb: final heading %h, position (%h, %h)", sb.yaw_acc, sb.x_acc, sb.y_acc);
    if (sb.fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/jpdr_pkg.sv
rtl/core/jpdr_ctrl.sv
rtl/core/jpdr_dp.sv
rtl/core/joystick_pose_dead_reckoning_top.sv
bench/joystick_pose_dead_reckoning_top_test.sv
